[hdl/gray_world_white_balance_core_assert.svh]
// assertion macros shared by the gray-world white balance rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef GRAY_WORLD_WHITE_BALANCE_CORE_ASSERT_SVH
`define GRAY_WORLD_WHITE_BALANCE_CORE_ASSERT_SVH

// checked on every clock edge outside reset
`define GWWB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define GWWB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/gwwb_pkg.sv]
// types and fixed constants of the gray-world white balance core
// no dependencies
package gwwb_pkg;

	localparam int PIX_W   = 8;
	localparam int SUM_W   = 28;
	localparam int GAIN_W  = 24;
	localparam int TOTAL_W = 30;
	localparam int NUM_CH  = 3;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [TOTAL_W-1:0] total_t;

	localparam gain_t GAIN_MAX = '1;
	localparam sum_t  SUM_MAX  = '1;
	localparam pix_t  PIX_MAX  = '1;

	localparam logic KIND_STATS = 1'b0;
	localparam logic KIND_APPLY = 1'b1;

endpackage

[hdl/gray_world_white_balance_core.sv]
// gray-world white balance core: statistics sums, iterative gain divider, gain apply
// depends on gwwb_pkg and gray_world_white_balance_core_assert.svh
//
// Usage: stream a frame once with kind=0 (statistics) and mark its last pixel with
// frame_end, then stream it again with kind=1 (apply); each apply request returns one
// balanced pixel. Statistics requests are taken one per cycle while the core is idle. A
// statistics request with frame_end makes the core busy while one shared restoring divider
// produces one quotient bit per cycle for the blue, green and red gains in turn; a channel
// whose sum is zero skips its division. An apply request occupies the core while one shared
// 8x24 multiplier scales the three channels on consecutive cycles, then the pixel moves to
// the output register. A finished pixel may wait in the output register while new requests
// are taken. Gains are unsigned with GAIN_FRAC_BITS fraction bits and reset to unity.
`include "gray_world_white_balance_core_assert.svh"

module gray_world_white_balance_core #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  gwwb_pkg::pix_t      blue_in,
	input  gwwb_pkg::pix_t      green_in,
	input  gwwb_pkg::pix_t      red_in,
	input  logic                frame_end,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output gwwb_pkg::pix_t      blue_out,
	output gwwb_pkg::pix_t      green_out,
	output gwwb_pkg::pix_t      red_out
);

	// dividend is (total << frac) plus half the denominator
	localparam int DW    = gwwb_pkg::TOTAL_W + 1 + GAIN_FRAC_BITS;
	localparam int CNT_W = $clog2(DW);

	localparam gwwb_pkg::gain_t UNITY = (GAIN_FRAC_BITS >= gwwb_pkg::GAIN_W) ?
		gwwb_pkg::GAIN_MAX : gwwb_pkg::gain_t'(64'd1 << GAIN_FRAC_BITS);
	localparam logic [32:0] HALF = 33'(64'd1 << (GAIN_FRAC_BITS - 1));

	// sequencer codes
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_TOTAL    = 3'd1;
	localparam logic [2:0] S_DIV_INIT = 3'd2;
	localparam logic [2:0] S_DIV_STEP = 3'd3;
	localparam logic [2:0] S_APPLY    = 3'd4;
	localparam logic [2:0] S_OUT      = 3'd5;

	localparam logic [1:0] CH_LAST = 2'(gwwb_pkg::NUM_CH - 1);

	logic [2:0] state_q;
	logic [1:0] ch_q;       // channel under work: 0 blue, 1 green, 2 red
	logic       out_valid_q;

	gwwb_pkg::sum_t  sum_q  [gwwb_pkg::NUM_CH];
	gwwb_pkg::gain_t gain_q [gwwb_pkg::NUM_CH];

	// payload registers
	gwwb_pkg::pix_t  pix_q  [gwwb_pkg::NUM_CH];
	gwwb_pkg::pix_t  res_q  [gwwb_pkg::NUM_CH];
	gwwb_pkg::pix_t  out_q  [gwwb_pkg::NUM_CH];
	gwwb_pkg::total_t total_q;
	gwwb_pkg::total_t den_q;
	gwwb_pkg::total_t rem_q;
	logic [DW-1:0]    dvd_q;
	gwwb_pkg::gain_t  quo_q;
	logic             ovf_q;
	logic [CNT_W-1:0] bit_q;

	logic            in_acc;
	logic            out_load;
	gwwb_pkg::pix_t  in_pix [gwwb_pkg::NUM_CH];
	logic [gwwb_pkg::SUM_W:0] sum_add [gwwb_pkg::NUM_CH];
	gwwb_pkg::sum_t  sum_nxt [gwwb_pkg::NUM_CH];

	// divider datapath
	gwwb_pkg::total_t    den_c;
	logic [DW-1:0]       dvd_init;
	logic [gwwb_pkg::TOTAL_W:0] trial;
	logic [gwwb_pkg::TOTAL_W:0] diff;
	logic                q_bit;
	logic                chan_zero;
	logic                div_last;

	// multiplier datapath
	logic [31:0]     prod;
	logic [32:0]     rnd;
	logic [32:0]     shf;
	gwwb_pkg::pix_t  scaled;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign blue_out  = out_q[0];
	assign green_out = out_q[1];
	assign red_out   = out_q[2];

	assign in_pix[0] = blue_in;
	assign in_pix[1] = green_in;
	assign in_pix[2] = red_in;

	// saturating accumulate of the incoming pixel
	always_comb begin
		for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
			sum_add[c] = {1'b0, sum_q[c]} + (gwwb_pkg::SUM_W + 1)'(in_pix[c]);
			sum_nxt[c] = sum_add[c][gwwb_pkg::SUM_W] ? gwwb_pkg::SUM_MAX :
				sum_add[c][gwwb_pkg::SUM_W-1:0];
		end
	end

	// denominator 3*sum and rounded dividend for the selected channel
	assign den_c     = {1'b0, sum_q[ch_q], 1'b0} + {2'b00, sum_q[ch_q]};
	assign dvd_init  = (DW'(total_q) << GAIN_FRAC_BITS) + DW'(den_c >> 1);
	assign chan_zero = (sum_q[ch_q] == '0);

	// one restoring step per cycle
	assign trial    = {rem_q, dvd_q[DW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign q_bit    = (trial >= {1'b0, den_q});
	assign div_last = (bit_q == '0);

	// shared multiplier with round half up and clamp
	assign prod   = {24'd0, pix_q[ch_q]} * {8'd0, gain_q[ch_q]};
	assign rnd    = {1'b0, prod} + HALF;
	assign shf    = rnd >> GAIN_FRAC_BITS;
	assign scaled = (shf > 33'(gwwb_pkg::PIX_MAX)) ? gwwb_pkg::PIX_MAX : shf[7:0];

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
				sum_q[c]  <= '0;
				gain_q[c] <= UNITY;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					ch_q <= '0;
					if (in_acc) begin
						if (kind == gwwb_pkg::KIND_APPLY) begin
							state_q <= S_APPLY;
						end else begin
							for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
								sum_q[c] <= sum_nxt[c];
							end
							if (frame_end) begin
								state_q <= S_TOTAL;
							end
						end
					end
				end
				S_TOTAL: begin
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					if (chan_zero) begin
						gain_q[ch_q] <= gwwb_pkg::GAIN_MAX;
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
							for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
								sum_q[c] <= '0;
							end
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						state_q <= S_DIV_STEP;
					end
				end
				S_DIV_STEP: begin
					if (div_last) begin
						// any bit above the gain width means saturation
						gain_q[ch_q] <= (ovf_q || quo_q[gwwb_pkg::GAIN_W-1]) ?
							gwwb_pkg::GAIN_MAX : {quo_q[gwwb_pkg::GAIN_W-2:0], q_bit};
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
							for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
								sum_q[c] <= '0;
							end
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_APPLY: begin
					if (ch_q == CH_LAST) begin
						state_q <= S_OUT;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
				pix_q[c] <= in_pix[c];
			end
		end
		if (state_q == S_TOTAL) begin
			total_q <= gwwb_pkg::TOTAL_W'(sum_q[0]) + gwwb_pkg::TOTAL_W'(sum_q[1])
				+ gwwb_pkg::TOTAL_W'(sum_q[2]);
		end
		if (state_q == S_DIV_INIT) begin
			den_q <= den_c;
			dvd_q <= dvd_init;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			bit_q <= CNT_W'(DW - 1);
		end
		if (state_q == S_DIV_STEP) begin
			rem_q <= q_bit ? diff[gwwb_pkg::TOTAL_W-1:0] : trial[gwwb_pkg::TOTAL_W-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[gwwb_pkg::GAIN_W-2:0], q_bit};
			ovf_q <= ovf_q | quo_q[gwwb_pkg::GAIN_W-1];
			bit_q <= bit_q - 1'b1;
		end
		if (state_q == S_APPLY) begin
			res_q[ch_q] <= scaled;
		end
		if (out_load) begin
			for (int c = 0; c < gwwb_pkg::NUM_CH; c++) begin
				out_q[c] <= res_q[c];
			end
		end
	end

	// assertions
	`GWWB_ASSERT(a_frame_end_starts_gains,
		(in_acc && kind == gwwb_pkg::KIND_STATS && frame_end) |=> (state_q == S_TOTAL),
		"frame end did not start the gain computation")
	`GWWB_ASSERT(a_apply_starts_at_blue,
		(in_acc && kind == gwwb_pkg::KIND_APPLY) |=> (state_q == S_APPLY && ch_q == 2'd0),
		"apply request did not start at the blue channel")
	`GWWB_ASSERT(a_rem_below_den,
		(state_q == S_DIV_STEP) |-> (rem_q < den_q),
		"divider remainder not below denominator")
	`GWWB_ASSERT(a_sums_cleared,
		(state_q == S_IDLE && ($past(state_q) == S_DIV_STEP || $past(state_q) == S_DIV_INIT))
		|-> (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0),
		"channel sums not cleared after gain computation")
	`GWWB_ASSERT(a_ch_in_range, ch_q != 2'd3, "channel index out of range")

endmodule

[dv/tb_gray_world_white_balance_core.sv]
// testbench for the gray-world white balance core: statistics frames, gain updates, apply
// depends on gwwb_pkg and the gray_world_white_balance_core rtl
// self-checking: a predictor built into this file checks every balanced pixel
`timescale 1ns / 1ps

module tb_gray_world_white_balance_core;

	localparam int FRAC        = 16;
	localparam int LONG_PIXELS = 48;        // one long full-rate frame, blue pinned at 255
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 300;       // covers a trailing gain update
	localparam int LIMIT       = 4000000;

	// one queued request and the pacing that goes with it
	typedef struct {
		logic kind;
		gwwb_pkg::pix_t b;
		gwwb_pkg::pix_t g;
		gwwb_pkg::pix_t r;
		logic fe;
		int   gap;
		bit   drain;
	} pixel_req_t;

	typedef struct {
		gwwb_pkg::pix_t b;
		gwwb_pkg::pix_t g;
		gwwb_pkg::pix_t r;
	} balanced_t;

	logic clk;
	logic arst_n = 1'b0;

	logic           in_valid  = 1'b0;
	logic           kind      = gwwb_pkg::KIND_STATS;
	gwwb_pkg::pix_t blue_in   = '0;
	gwwb_pkg::pix_t green_in  = '0;
	gwwb_pkg::pix_t red_in    = '0;
	logic           frame_end = 1'b0;
	logic           in_stall;

	logic           out_valid;
	logic           out_stall = 1'b0;
	gwwb_pkg::pix_t blue_out;
	gwwb_pkg::pix_t green_out;
	gwwb_pkg::pix_t red_out;

	pixel_req_t pending_px[$];
	balanced_t  balanced_q[$];

	// predictor state: per-channel sums and gains in force
	gwwb_pkg::sum_t  sum_b, sum_g, sum_r;
	gwwb_pkg::gain_t gain_b, gain_g, gain_r;

	int n_pushed    = 0;
	int n_accepted  = 0;
	int n_stats     = 0;
	int n_apply     = 0;
	int n_frames    = 0;
	int n_results   = 0;
	int n_errors    = 0;
	int hold_at     = 32'h7fffffff;
	int cycle_cnt   = 0;
	int idle_cnt    = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	gray_world_white_balance_core #(
		.GAIN_FRAC_BITS(FRAC)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.blue_in  (blue_in),
		.green_in (green_in),
		.red_in   (red_in),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blue_out (blue_out),
		.green_out(green_out),
		.red_out  (red_out)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// channel sum that sticks at its maximum instead of wrapping
	function automatic gwwb_pkg::sum_t sum_add(gwwb_pkg::sum_t s, gwwb_pkg::pix_t v);
		logic [gwwb_pkg::SUM_W:0] t;
		t = (gwwb_pkg::SUM_W + 1)'(s) + (gwwb_pkg::SUM_W + 1)'(v);
		return (t > (gwwb_pkg::SUM_W + 1)'(gwwb_pkg::SUM_MAX)) ? gwwb_pkg::SUM_MAX :
			t[gwwb_pkg::SUM_W-1:0];
	endfunction

	// gray-world gain: total / (3 * channel), rounded half up, saturated
	function automatic gwwb_pkg::gain_t gray_gain(longint unsigned total, gwwb_pkg::sum_t chan);
		longint unsigned den, q;
		if (chan == '0)
			return gwwb_pkg::GAIN_MAX;   // empty channel gets the largest gain
		den = 64'(chan) * 64'd3;
		q = ((total << FRAC) + den / 2) / den;
		return (q > 64'(gwwb_pkg::GAIN_MAX)) ? gwwb_pkg::GAIN_MAX : gwwb_pkg::gain_t'(q);
	endfunction

	// scale one channel by its gain, round half up, clip to 8 bits
	function automatic gwwb_pkg::pix_t scale_chan(gwwb_pkg::pix_t v, gwwb_pkg::gain_t g);
		longint unsigned p;
		p = (64'(v) * 64'(g) + (64'd1 << (FRAC - 1))) >> FRAC;
		return (p > 64'(gwwb_pkg::PIX_MAX)) ? gwwb_pkg::PIX_MAX : gwwb_pkg::pix_t'(p);
	endfunction

	// advance the predictor by one accepted request
	task automatic predict_pixel(logic k, gwwb_pkg::pix_t b, gwwb_pkg::pix_t g,
			gwwb_pkg::pix_t r, logic fe);
		longint unsigned total;
		balanced_t px;
		if (k == gwwb_pkg::KIND_STATS) begin
			n_stats++;
			sum_b = sum_add(sum_b, b);
			sum_g = sum_add(sum_g, g);
			sum_r = sum_add(sum_r, r);
			// last statistics pixel: new gains from the sums, sums restart
			if (fe) begin
				total = 64'(sum_b) + 64'(sum_g) + 64'(sum_r);
				gain_b = gray_gain(total, sum_b);
				gain_g = gray_gain(total, sum_g);
				gain_r = gray_gain(total, sum_r);
				sum_b = '0;
				sum_g = '0;
				sum_r = '0;
				n_frames++;
			end
		end else begin
			// apply pixel: frame_end has no meaning here
			n_apply++;
			px.b = scale_chan(b, gain_b);
			px.g = scale_chan(g, gain_g);
			px.r = scale_chan(r, gain_r);
			balanced_q.insert(balanced_q.size(), px);
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// idle cycles before a request: stretches of back-to-back traffic between random ones
	function automatic int pick_gap();
		return ((n_pushed / 96) % 3 == 0) ? 0 : int'($urandom_range(0, 10));
	endfunction

	// gap < 0 means draw one; drain holds the request until all pixels are back
	task automatic queue_pixel(logic k, gwwb_pkg::pix_t b, gwwb_pkg::pix_t g,
			gwwb_pkg::pix_t r, logic fe, int gap, bit drain);
		pixel_req_t req;
		req.kind  = k;
		req.b     = b;
		req.g     = g;
		req.r     = r;
		req.fe    = fe;
		req.gap   = (gap < 0) ? pick_gap() : gap;
		req.drain = drain;
		pending_px.insert(pending_px.size(), req);
		n_pushed++;
	endtask

	// per-frame channel ceiling, so gains spread from tiny to saturated
	function automatic int pick_cap();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 8;
			2: return 60;
			default: return 255;
		endcase
	endfunction

	// any 8-bit value up to a ceiling
	function automatic gwwb_pkg::pix_t rand_pix(int cap);
		return gwwb_pkg::pix_t'($urandom_range(0, cap));
	endfunction

	// apply-side channel value, extremes favored
	function automatic gwwb_pkg::pix_t apply_val();
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) == 1) ? gwwb_pkg::PIX_MAX : gwwb_pkg::pix_t'(0);
		return rand_pix(255);
	endfunction

	// ---------------------------------------------------------------
	// driver: presents queued requests, feeds the predictor on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drv
		logic took;
		pixel_req_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			kind      <= gwwb_pkg::KIND_STATS;
			blue_in   <= '0;
			green_in  <= '0;
			red_in    <= '0;
			frame_end <= 1'b0;
			idle_cnt = 0;
			sum_b = '0;
			sum_g = '0;
			sum_r = '0;
			// gains start at unity
			gain_b = gwwb_pkg::gain_t'(1) << FRAC;
			gain_g = gwwb_pkg::gain_t'(1) << FRAC;
			gain_r = gwwb_pkg::gain_t'(1) << FRAC;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				predict_pixel(kind, blue_in, green_in, red_in, frame_end);
				n_accepted++;
				idle_cnt = 0;
			end
			// payload stays put while stalled; only move on when free
			if (!in_valid || took) begin
				if (pending_px.size() != 0 && idle_cnt >= pending_px[0].gap &&
						!(pending_px[0].drain && balanced_q.size() != 0)) begin
					nxt = pending_px.pop_front();
					kind      <= nxt.kind;
					blue_in   <= nxt.b;
					green_in  <= nxt.g;
					red_in    <= nxt.r;
					frame_end <= nxt.fe;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					idle_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each balanced pixel, drives the receiver stall
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : mon
		balanced_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (balanced_q.size() == 0) begin
					$error("balanced pixel with none expected: b=%0d g=%0d r=%0d",
						blue_out, green_out, red_out);
					n_errors++;
				end else begin
					want = balanced_q.pop_front();
					if (blue_out !== want.b) begin
						$error("blue_out: expected %0d, actual %0d", want.b, blue_out);
						n_errors++;
					end
					if (green_out !== want.g) begin
						$error("green_out: expected %0d, actual %0d", want.g, green_out);
						n_errors++;
					end
					if (red_out !== want.r) begin
						$error("red_out: expected %0d, actual %0d", want.r, red_out);
						n_errors++;
					end
				end
				// every other block of 64 pixels goes through with no stall at all
				stall_left = n_results[6] ? 0 : int'($urandom_range(0, 10));
			end else if (out_valid && stall_left > 0) begin
				stall_left--;
			end
			// one long hold-off once the pressure burst starts, so the core backs up
			if (!hold_done && n_accepted >= hold_at) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (hold_left > 0) || (stall_left > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus sequence and end of run
	// ---------------------------------------------------------------
	initial begin : stim
		int cap_b, cap_g, cap_r;
		int n_st, n_ap, target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// apply before any statistics: unity gains
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd255, 8'd255, 8'd255, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd0,   8'd0,   8'd0,   1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd1,   8'd128, 8'd254, 1'b0, -1, 1'b0);
		// frame_end on an apply request must not touch the gains
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd170, 8'd85,  8'd51,  1'b1, -1, 1'b0);
		// single-pixel frame with a zero blue sum: blue gain pinned at max
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd0,   8'd100, 8'd200, 1'b1, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd255, 8'd1,   8'd0,   1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd1,   8'd200, 8'd255, 1'b0, -1, 1'b0);
		// all-black frame: every sum zero, every gain max
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd0,   8'd0,   8'd0,   1'b1, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd0,   8'd0,   8'd0,   1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd1,   8'd2,   8'd255, 1'b0, -1, 1'b0);
		// tiny blue against full green/red: quotient overflows the gain width
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd1,   8'd255, 8'd255, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd0,   8'd255, 8'd255, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd0,   8'd255, 8'd255, 1'b1, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd1,   8'd255, 8'd255, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd0,   8'd128, 8'd1,   1'b0, -1, 1'b0);
		// extremes spread over two pixels
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd255, 8'd0,   8'd128, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd0,   8'd255, 8'd127, 1'b1, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd255, 8'd255, 8'd255, 1'b0, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd128, 8'd64,  8'd32,  1'b0, -1, 1'b0);
		// neutral gray frame: gains back to exactly unity
		queue_pixel(gwwb_pkg::KIND_STATS, 8'd100, 8'd100, 8'd100, 1'b1, -1, 1'b0);
		queue_pixel(gwwb_pkg::KIND_APPLY, 8'd200, 8'd13,  8'd99,  1'b0, -1, 1'b0);

		// pressure burst: receiver holds off while back-to-back apply requests pile up
		for (int i = 0; i < 4; i++)
			queue_pixel(gwwb_pkg::KIND_STATS, rand_pix(255), rand_pix(255), rand_pix(255),
				i == 3, -1, 1'b0);
		hold_at = n_pushed;
		for (int i = 0; i < 40; i++)
			queue_pixel(gwwb_pkg::KIND_APPLY, apply_val(), apply_val(), apply_val(), 1'b0, 0,
				1'b0);

		// one long frame at full rate, after the sender drains
		for (int i = 0; i < LONG_PIXELS; i++) begin
			while (pending_px.size() > 256)
				@(posedge clk);
			queue_pixel(gwwb_pkg::KIND_STATS, gwwb_pkg::PIX_MAX, rand_pix(255), rand_pix(255),
				i == LONG_PIXELS - 1, 0, i == 0);
		end
		for (int i = 0; i < 8; i++)
			queue_pixel(gwwb_pkg::KIND_APPLY, apply_val(), apply_val(), apply_val(), 1'b0, -1,
				1'b0);

		// random frames: mostly statistics then apply, with broken frames mixed in
		target = n_pushed + 930;
		while (n_pushed < target) begin
			while (pending_px.size() > 256)
				@(posedge clk);
			cap_b = pick_cap();
			cap_g = pick_cap();
			cap_r = pick_cap();
			n_st = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 300)) :
				int'($urandom_range(1, 16));
			if (n_st > target - n_pushed)
				n_st = target - n_pushed;
			for (int i = 0; i < n_st; i++) begin
				// stray apply request inside a statistics run
				if ($urandom_range(0, 19) == 0)
					queue_pixel(gwwb_pkg::KIND_APPLY, apply_val(), apply_val(), apply_val(),
						$urandom_range(0, 1) == 1, -1, 1'b0);
				// frame end usually on the last pixel, sometimes missing or early
				queue_pixel(gwwb_pkg::KIND_STATS, rand_pix(cap_b), rand_pix(cap_g),
					rand_pix(cap_r),
					(i == n_st - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
					-1, 1'b0);
			end
			n_ap = $urandom_range(0, 25);
			for (int i = 0; i < n_ap; i++)
				queue_pixel(gwwb_pkg::KIND_APPLY, apply_val(), apply_val(), apply_val(),
					$urandom_range(0, 15) == 0, -1, 1'b0);
		end

		// wait for every request to go in and every pixel to come back
		while (pending_px.size() != 0 || in_valid)
			@(posedge clk);
		while (balanced_q.size() != 0)
			@(posedge clk);
		// let a trailing gain update finish; anything that shows up now is unexpected
		repeat (TAIL_CYCLES) @(posedge clk);

		if (balanced_q.size() != 0) begin
			$error("%0d balanced pixels never arrived", balanced_q.size());
			n_errors++;
		end
		$display("run covered %0d requests: %0d statistics, %0d apply, %0d gain updates",
			n_accepted, n_stats, n_apply, n_frames);
		$display("checked %0d balanced pixels in %0d cycles, %0d mismatches",
			n_results, cycle_cnt, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
